// ----- hdl/afx_pkg.sv -----
// ----------------------------------------------------------------------------
// afx_pkg
// Shared types and constants of the asynchronous frame transmitter: frame
// limits, line codes, register indexes, the command that passes from the
// front end to the back end, and the back end's sequencer states.
// ----------------------------------------------------------------------------
package afx_pkg;

    localparam int MAX_FRAME_BYTES     = 256;
    localparam int FRAME_PAYLOAD_LIMIT = MAX_FRAME_BYTES - 4;
    localparam int COUNT_W             = $clog2(MAX_FRAME_BYTES);

    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int QPTR_W          = $clog2(CMD_QUEUE_DEPTH);

    localparam int CRC_W      = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0] FLAG_BYTE  = 8'h7e;
    localparam logic [7:0] STUFF_BYTE = 8'h9d;
    localparam logic [7:0] PAD_BYTE   = 8'h00;

    // Control bytes that end a message without closing the frame.
    localparam logic [7:0] CTRL_KEEP_A = 8'o50;
    localparam logic [7:0] CTRL_KEEP_B = 8'o51;
    localparam logic [7:0] CTRL_KEEP_C = 8'o52;

    localparam logic OP_PAYLOAD = 1'b0;
    localparam logic OP_END     = 1'b1;

    localparam logic [CRC_W-1:0] CRC_POLY_RESET  = 16'ha001;
    localparam logic [CRC_W-1:0] CRC_START_RESET = 16'h4040;

    typedef enum logic {
        REG_CRC_POLY  = 1'b0,
        REG_CRC_START = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] start;
    } t_crc_cfg;

    typedef struct packed {
        logic [11:0] channel;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [1:0]  nbytes;
        logic        flags;
    } t_cmd;

    typedef enum logic [3:0] {
        TX_IDLE,
        TX_CLOSE_LO,
        TX_CLOSE_LO_PAD,
        TX_CLOSE_HI,
        TX_CLOSE_HI_PAD,
        TX_FLAG_A,
        TX_FLAG_B,
        TX_OPEN_FLAG_A,
        TX_OPEN_FLAG_B,
        TX_HDR_HI,
        TX_HDR_LO,
        TX_DATA,
        TX_DATA_PAD
    } t_tx_state;

endpackage

// ----- hdl/afx_if.sv -----
// ----------------------------------------------------------------------------
// afx_in_if / afx_out_if
// Valid/ready channels of the transmitter: tagged message words in, framed
// line bytes out.
// ----------------------------------------------------------------------------
interface afx_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [11:0] channel;
    logic [7:0]  value;

    modport source (output valid, output opcode, output channel, output value, input ready);
    modport sink   (input valid, input opcode, input channel, input value, output ready);
endinterface

interface afx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       last_of_run;

    modport source (output valid, output line_byte, output last_of_run, input ready);
    modport sink   (input valid, input line_byte, input last_of_run, output ready);
endinterface

// ----- hdl/async_frame_transmitter.sv -----
// ----------------------------------------------------------------------------
// async_frame_transmitter
// Framed, byte-stuffed serial encoder with a reflected CRC-16.
//
// i_item carries channel-tagged message words (payload byte, or end of
// message with a control byte); o_line carries the line bytes, with
// last_of_run marking the final byte caused by each word. Both are
// valid/ready channels. The APB port holds the CRC polynomial (offset 0)
// and the CRC start value (offset 4); write it only while the block is idle.
// A front end classifies words into a four-entry command queue; the back end
// sequencer pulls commands and emits one line byte per cycle into an output
// register while the receiver takes them. A plain payload byte gives one
// line byte, a word that opens a frame five; a word that produces nothing
// is retired without one. A word passes the queue and the sequencer state
// before its first byte reaches the output register. That register is the
// only rate limit, and words keep being accepted while the queue has room.
// Reset drops any open frame, clears the channel, count and CRC and empties the
// queue; the registers return to 0xa001 and 0x4040. When the receiver stalls
// the output byte holds, the sequencer waits and the queue fills up.
// ----------------------------------------------------------------------------
module async_frame_transmitter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [afx_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [afx_pkg::APB_DATA_W-1:0] pwdata,
    output logic [afx_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    afx_in_if.sink                         i_item,
    afx_out_if.source                      o_line
);

    afx_pkg::t_crc_cfg w_cfg;
    afx_pkg::t_cmd     w_cmd;
    logic              w_cmd_valid;
    logic              w_cmd_pop;

    afx_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    afx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    afx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .o_line      (o_line)
    );

endmodule

// ----- hdl/afx_regs.sv -----
// ----------------------------------------------------------------------------
// afx_regs
// APB register file holding the CRC polynomial and the CRC start value.
// ----------------------------------------------------------------------------
module afx_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [afx_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [afx_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [afx_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output afx_pkg::t_crc_cfg                  o_cfg
);

    logic [afx_pkg::CRC_W-1:0] r_poly;
    logic [afx_pkg::CRC_W-1:0] r_start;
    logic                      w_write;
    afx_pkg::t_reg_idx         w_idx;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_idx   = afx_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly  <= afx_pkg::CRC_POLY_RESET;
            r_start <= afx_pkg::CRC_START_RESET;
        end else if (w_write) begin
            case (w_idx)
                afx_pkg::REG_CRC_POLY: begin
                    r_poly <= pwdata[afx_pkg::CRC_W-1:0];
                end
                afx_pkg::REG_CRC_START: begin
                    r_start <= pwdata[afx_pkg::CRC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            afx_pkg::REG_CRC_POLY:  prdata = {{(afx_pkg::APB_DATA_W-afx_pkg::CRC_W){1'b0}}, r_poly};
            afx_pkg::REG_CRC_START: prdata = {{(afx_pkg::APB_DATA_W-afx_pkg::CRC_W){1'b0}}, r_start};
            default:                prdata = '0;
        endcase
    end

    assign o_cfg.poly  = r_poly;
    assign o_cfg.start = r_start;

endmodule

// ----- hdl/afx_front.sv -----
// ----------------------------------------------------------------------------
// afx_front
// Accepts message words, turns each into a command (payload bytes to send
// and whether the frame closes with flags) and queues it for the back end.
// ----------------------------------------------------------------------------
module afx_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    afx_in_if.sink       i_item,
    output afx_pkg::t_cmd o_cmd,
    output logic         o_cmd_valid,
    input  logic         i_cmd_pop
);

    afx_pkg::t_cmd               r_queue [afx_pkg::CMD_QUEUE_DEPTH];
    logic [afx_pkg::QPTR_W-1:0]  r_wr;
    logic [afx_pkg::QPTR_W-1:0]  r_rd;
    logic [afx_pkg::QPTR_W:0]    r_cnt;
    logic [afx_pkg::QPTR_W:0]    n_cnt;
    afx_pkg::t_cmd               w_cmd;
    logic                        w_push;

    always_comb begin
        w_cmd.channel = i_item.channel;
        w_cmd.byte0   = i_item.value;
        w_cmd.byte1   = afx_pkg::PAD_BYTE;
        w_cmd.nbytes  = 2'd1;
        w_cmd.flags   = 1'b0;
        if (i_item.opcode == afx_pkg::OP_END) begin
            // End of message: escape code, then the control byte; a pad control byte sends nothing.
            w_cmd.byte0 = afx_pkg::STUFF_BYTE;
            w_cmd.byte1 = i_item.value;
            if (i_item.value == afx_pkg::PAD_BYTE) begin
                w_cmd.nbytes = 2'd0;
            end else begin
                w_cmd.nbytes = 2'd2;
                w_cmd.flags  = !(i_item.value inside {afx_pkg::CTRL_KEEP_A,
                                                      afx_pkg::CTRL_KEEP_B,
                                                      afx_pkg::CTRL_KEEP_C});
            end
        end else if (i_item.value == afx_pkg::STUFF_BYTE) begin
            w_cmd.nbytes = 2'd2;
        end
    end

    assign i_item.ready = (r_cnt != (afx_pkg::QPTR_W+1)'(afx_pkg::CMD_QUEUE_DEPTH));
    assign w_push       = i_item.valid && i_item.ready;
    assign o_cmd_valid  = (r_cnt != '0);
    assign o_cmd        = r_queue[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_cmd_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && i_cmd_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr] <= w_cmd;
        end
    end

endmodule

// ----- hdl/afx_back.sv -----
// ----------------------------------------------------------------------------
// afx_back
// Frame sequencer: executes queued commands one line byte per cycle while
// the output is not stalled, keeps the open frame's channel, payload count
// and running CRC, and drives the output register.
// ----------------------------------------------------------------------------
module afx_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  afx_pkg::t_crc_cfg i_cfg,
    input  afx_pkg::t_cmd     i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    afx_out_if.source         o_line
);

    afx_pkg::t_tx_state             r_state;
    afx_pkg::t_tx_state             n_state;
    afx_pkg::t_tx_state             w_step_state;
    logic [11:0]                    r_cur;
    logic [11:0]                    n_cur;
    logic [afx_pkg::COUNT_W-1:0]    r_count;
    logic [afx_pkg::COUNT_W-1:0]    n_count;
    logic [afx_pkg::CRC_W-1:0]      r_crc;
    logic [afx_pkg::CRC_W-1:0]      n_crc;
    logic [7:0]                     r_b0;
    logic [7:0]                     r_b1;
    logic [7:0]                     n_b0;
    logic [7:0]                     n_b1;
    logic [1:0]                     r_nb;
    logic [1:0]                     n_nb;
    logic [1:0]                     r_idx;
    logic [1:0]                     n_idx;
    logic                           r_flags;
    logic                           n_flags;
    logic                           r_o_valid;
    logic [7:0]                     r_o_byte;
    logic                           r_o_last;
    logic [7:0]                     w_byte;
    logic [afx_pkg::CRC_W-1:0]      w_crc_in;
    logic [afx_pkg::CRC_W-1:0]      w_crc_out;
    logic                           w_adv;
    logic                           w_free;

    localparam logic [afx_pkg::COUNT_W-1:0] LIMIT =
        afx_pkg::COUNT_W'(afx_pkg::FRAME_PAYLOAD_LIMIT);

    function automatic logic [15:0] f_crc_byte(input logic [15:0] crc,
                                               input logic [7:0]  x,
                                               input logic [15:0] poly);
        logic [15:0] t;
        t = {8'h00, crc[7:0] ^ x};
        for (int i = 0; i < 8; i++) begin
            t = t[0] ? ((t >> 1) ^ poly) : (t >> 1);
        end
        return t ^ {8'h00, crc[15:8]};
    endfunction

    // What follows once the current step is done: more payload (opening a frame first
    // if none is open), the CRC and flags that close it (only flags if none is open), or nothing.
    function automatic afx_pkg::t_tx_state f_cont(input logic cnt_zero,
                                                  input logic more_data,
                                                  input logic flags_pend);
        afx_pkg::t_tx_state s;
        if (more_data) begin
            s = cnt_zero ? afx_pkg::TX_OPEN_FLAG_A : afx_pkg::TX_DATA;
        end else if (flags_pend) begin
            s = cnt_zero ? afx_pkg::TX_FLAG_A : afx_pkg::TX_CLOSE_LO;
        end else begin
            s = afx_pkg::TX_IDLE;
        end
        return s;
    endfunction

    assign w_adv  = (r_state != afx_pkg::TX_IDLE) && (!r_o_valid || o_line.ready);
    assign w_free = (r_state == afx_pkg::TX_IDLE) ||
                    (w_adv && (w_step_state == afx_pkg::TX_IDLE));
    assign o_cmd_pop = w_free && i_cmd_valid;

    // Output side: the byte of the current step and the CRC update.
    always_comb begin
        case (r_state)
            afx_pkg::TX_CLOSE_LO:    w_byte = r_crc[7:0];
            afx_pkg::TX_CLOSE_HI:    w_byte = r_crc[15:8];
            afx_pkg::TX_FLAG_A,
            afx_pkg::TX_FLAG_B,
            afx_pkg::TX_OPEN_FLAG_A,
            afx_pkg::TX_OPEN_FLAG_B: w_byte = afx_pkg::FLAG_BYTE;
            afx_pkg::TX_HDR_HI:      w_byte = {1'b1, r_cur[11:6], 1'b0};
            afx_pkg::TX_HDR_LO:      w_byte = {1'b1, r_cur[5:0], 1'b0};
            afx_pkg::TX_DATA:        w_byte = r_idx[0] ? r_b1 : r_b0;
            default:                 w_byte = afx_pkg::PAD_BYTE;
        endcase
        w_crc_in  = (r_state == afx_pkg::TX_HDR_HI) ? i_cfg.start : r_crc;
        w_crc_out = f_crc_byte(w_crc_in, w_byte, i_cfg.poly);
    end

    // Next state of the sequencer and its context.
    always_comb begin
        w_step_state = r_state;
        n_count      = r_count;
        n_crc        = r_crc;
        n_idx        = r_idx;
        n_flags      = r_flags;
        n_cur        = r_cur;
        n_b0         = r_b0;
        n_b1         = r_b1;
        n_nb         = r_nb;
        case (r_state)
            afx_pkg::TX_CLOSE_LO: begin
                w_step_state = (w_byte == afx_pkg::FLAG_BYTE) ? afx_pkg::TX_CLOSE_LO_PAD
                                                              : afx_pkg::TX_CLOSE_HI;
            end
            afx_pkg::TX_CLOSE_LO_PAD: begin
                w_step_state = afx_pkg::TX_CLOSE_HI;
            end
            afx_pkg::TX_CLOSE_HI: begin
                if (w_byte == afx_pkg::FLAG_BYTE) begin
                    w_step_state = afx_pkg::TX_CLOSE_HI_PAD;
                end else begin
                    n_count      = '0;
                    w_step_state = f_cont(1'b1, r_idx < r_nb, r_flags);
                end
            end
            afx_pkg::TX_CLOSE_HI_PAD: begin
                n_count      = '0;
                w_step_state = f_cont(1'b1, r_idx < r_nb, r_flags);
            end
            afx_pkg::TX_FLAG_A: begin
                w_step_state = afx_pkg::TX_FLAG_B;
            end
            afx_pkg::TX_FLAG_B: begin
                n_flags      = 1'b0;
                w_step_state = f_cont(r_count == '0, r_idx < r_nb, 1'b0);
            end
            afx_pkg::TX_OPEN_FLAG_A: begin
                w_step_state = afx_pkg::TX_OPEN_FLAG_B;
            end
            afx_pkg::TX_OPEN_FLAG_B: begin
                w_step_state = afx_pkg::TX_HDR_HI;
            end
            afx_pkg::TX_HDR_HI: begin
                n_crc        = w_crc_out;
                w_step_state = afx_pkg::TX_HDR_LO;
            end
            afx_pkg::TX_HDR_LO: begin
                n_crc        = w_crc_out;
                w_step_state = afx_pkg::TX_DATA;
            end
            afx_pkg::TX_DATA: begin
                n_crc   = w_crc_out;
                n_count = r_count + 1'b1;
                n_idx   = r_idx + 1'b1;
                if (w_byte == afx_pkg::FLAG_BYTE) begin
                    w_step_state = afx_pkg::TX_DATA_PAD;
                end else if (n_count >= LIMIT) begin
                    w_step_state = afx_pkg::TX_CLOSE_LO;
                end else begin
                    w_step_state = f_cont(1'b0, n_idx < r_nb, r_flags);
                end
            end
            afx_pkg::TX_DATA_PAD: begin
                if (r_count >= LIMIT) begin
                    w_step_state = afx_pkg::TX_CLOSE_LO;
                end else begin
                    w_step_state = f_cont(1'b0, r_idx < r_nb, r_flags);
                end
            end
            default: begin
                w_step_state = afx_pkg::TX_IDLE;
            end
        endcase

        n_state = w_adv ? w_step_state : r_state;
        if (!w_adv) begin
            n_count = r_count;
            n_crc   = r_crc;
            n_idx   = r_idx;
            n_flags = r_flags;
        end

        if (o_cmd_pop) begin
            n_cur   = i_cmd.channel;
            n_b0    = i_cmd.byte0;
            n_b1    = i_cmd.byte1;
            n_nb    = i_cmd.nbytes;
            n_idx   = '0;
            n_flags = i_cmd.flags;
            // A channel change closes the open frame before anything else.
            if ((i_cmd.channel != r_cur) && (n_count != '0)) begin
                n_state = afx_pkg::TX_CLOSE_LO;
            end else begin
                n_state = f_cont(n_count == '0, i_cmd.nbytes != 2'd0, i_cmd.flags);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= afx_pkg::TX_IDLE;
            r_cur     <= '0;
            r_count   <= '0;
            r_crc     <= '0;
            r_nb      <= '0;
            r_idx     <= '0;
            r_flags   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_count <= n_count;
            r_crc   <= n_crc;
            r_nb    <= n_nb;
            r_idx   <= n_idx;
            r_flags <= n_flags;
            if (w_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_line.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0 <= n_b0;
        r_b1 <= n_b1;
        if (w_adv) begin
            r_o_byte <= w_byte;
            r_o_last <= (w_step_state == afx_pkg::TX_IDLE);
        end
    end

    assign o_line.valid       = r_o_valid;
    assign o_line.line_byte   = r_o_byte;
    assign o_line.last_of_run = r_o_last;

endmodule

// ----- hdl/afx_checker.sv -----
// ----------------------------------------------------------------------------
// afx_checker
// Port-level checks of the frame transmitter, bound to the top level.
// ----------------------------------------------------------------------------
module afx_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [7:0]                     i_out_byte,
    input logic                           i_out_last,
    input logic                           i_psel,
    input logic                           i_penable,
    input logic                           i_pwrite,
    input logic                           i_pready,
    input logic [afx_pkg::APB_ADDR_W-1:0] i_paddr,
    input logic [afx_pkg::APB_DATA_W-1:0] i_pwdata,
    input logic [afx_pkg::APB_DATA_W-1:0] i_prdata
);

    logic w_write;

    assign w_write = i_psel && i_penable && i_pwrite && i_pready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("line byte changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("line byte offered right after reset");

    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_write |=> !(i_psel && !i_pwrite && (i_paddr[2] == $past(i_paddr[2]))) ||
            (i_prdata[afx_pkg::CRC_W-1:0] == $past(i_pwdata[afx_pkg::CRC_W-1:0])))
        else $error("register read back differs from the value written");

    a_apb_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready && (i_prdata[afx_pkg::APB_DATA_W-1:afx_pkg::CRC_W] == '0))
        else $error("APB ready low or unused read bits set");

endmodule

bind async_frame_transmitter afx_checker u_afx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_line.valid),
    .i_out_ready (o_line.ready),
    .i_out_byte  (o_line.line_byte),
    .i_out_last  (o_line.last_of_run),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_pready    (pready),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);
